FILE: rtl/ps2mpt_pkg.sv
`default_nettype none

package ps2mpt_pkg;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 12;
  localparam int unsigned ExtW  = 13;
  localparam int unsigned IdxW  = 1;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegScreenWidth  = 1'd0;
  localparam logic [IdxW-1:0] RegScreenHeight = 1'd1;

  // configuration reset values
  localparam logic [ExtW-1:0] WidthReset  = 13'd640;
  localparam logic [ExtW-1:0] HeightReset = 13'd480;

  // packet phases
  typedef logic [1:0] phase_t;
  localparam phase_t PhStatus = 2'd0;
  localparam phase_t PhDeltaX = 2'd1;
  localparam phase_t PhDeltaY = 2'd2;

  // status byte bits
  localparam int unsigned StLeft  = 0;
  localparam int unsigned StSync  = 3;
  localparam int unsigned StSignX = 4;
  localparam int unsigned StSignY = 5;
  localparam int unsigned StOvfX  = 6;
  localparam int unsigned StOvfY  = 7;

endpackage

`default_nettype wire

FILE: rtl/ps2_mouse_packet_tracker_unit.sv
`default_nettype none

// channel   direction  ports                                     width
// in        input      in_valid, in_ready, in_rx_byte            8
// out       output     out_valid, out_ready, out_pos_x/_pos_y    12, 12
//                      out_left_button                           1
// cfg       input      cfg_we, cfg_index, cfg_wdata              1, 13
//
// one byte is taken per cycle while in_ready is high; a completed packet shows
// its result in the output register in the cycle after the third byte is taken.
// the byte path is the phase decode, one signed add and a clamp compare
// per axis between the input handshake and the cursor/output registers.
// in_ready drops only while a result waits in the output register unclaimed.
// rst_n (synchronous) returns to phase 0, cursor 0,0 and extents 640x480.

module ps2_mouse_packet_tracker_unit #(
  parameter int unsigned POS_BITS = 12
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [ps2mpt_pkg::ByteW-1:0]      in_rx_byte,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [ps2mpt_pkg::PosW-1:0]       out_pos_x,
  output logic [ps2mpt_pkg::PosW-1:0]       out_pos_y,
  output logic                              out_left_button,
  input  wire                               cfg_we,
  input  wire  [ps2mpt_pkg::IdxW-1:0]       cfg_index,
  input  wire  [ps2mpt_pkg::ExtW-1:0]       cfg_wdata
);

  // signed working width: cursor or extent plus a 9-bit delta with room for sign
  localparam int unsigned SumW  = ((POS_BITS > ps2mpt_pkg::ExtW) ? POS_BITS
                                                                  : ps2mpt_pkg::ExtW) + 2;
  localparam int unsigned WideW = (POS_BITS > ps2mpt_pkg::PosW) ? POS_BITS
                                                                : ps2mpt_pkg::PosW;
  localparam logic [SumW-1:0] PosLimit = SumW'(1) << POS_BITS;

  logic [ps2mpt_pkg::ExtW-1:0]  width_r, height_r;
  ps2mpt_pkg::phase_t           phase_r, phase_nxt;
  logic [ps2mpt_pkg::ByteW-1:0] status_r, status_nxt;
  logic [ps2mpt_pkg::ByteW-1:0] dx_r, dx_nxt;
  logic [POS_BITS-1:0]          cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ps2mpt_pkg::PosW-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic                         left_r, left_nxt;

  logic                         in_fire;
  logic                         byte_ok;
  logic signed [SumW-1:0]       dx_ext, dy_ext, sum_x, sum_y;
  logic [SumW-1:0]              hi_x, hi_y;
  logic [WideW-1:0]             wide_x, wide_y;

  // largest coordinate for an extent: zero acts as one, capped at 2^POS_BITS-1
  function automatic logic [SumW-1:0] ext_max(input logic [ps2mpt_pkg::ExtW-1:0] e);
    logic [SumW-1:0] ev;
    ev = SumW'(e);
    if (ev == '0) begin
      ext_max = '0;
    end else if (ev > PosLimit) begin
      ext_max = PosLimit - SumW'(1);
    end else begin
      ext_max = ev - SumW'(1);
    end
  endfunction

  // clamp a signed sum into 0..hi
  function automatic logic [POS_BITS-1:0] clamp(input logic signed [SumW-1:0] v,
                                                input logic [SumW-1:0] hi);
    if (v[SumW-1]) begin
      clamp = '0;
    end else if ($unsigned(v) > hi) begin
      clamp = hi[POS_BITS-1:0];
    end else begin
      clamp = v[POS_BITS-1:0];
    end
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // status byte needs the sync bit and no overflow
  assign byte_ok = in_rx_byte[ps2mpt_pkg::StSync] &&
                   !in_rx_byte[ps2mpt_pkg::StOvfX] && !in_rx_byte[ps2mpt_pkg::StOvfY];

  // nine-bit deltas, y negated so it grows downward
  assign dx_ext = $signed({{(SumW-ps2mpt_pkg::ByteW){status_r[ps2mpt_pkg::StSignX]}}, dx_r});
  assign dy_ext = -$signed({{(SumW-ps2mpt_pkg::ByteW){status_r[ps2mpt_pkg::StSignY]}},
                            in_rx_byte});
  assign sum_x  = $signed(SumW'(cur_x_r)) + dx_ext;
  assign sum_y  = $signed(SumW'(cur_y_r)) + dy_ext;
  assign hi_x   = ext_max(width_r);
  assign hi_y   = ext_max(height_r);

  // packet assembly and cursor update
  always_comb begin
    phase_nxt     = phase_r;
    status_nxt    = status_r;
    dx_nxt        = dx_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    left_nxt      = left_r;
    wide_x        = WideW'(cur_x_r);
    wide_y        = WideW'(cur_y_r);
    if (in_fire) begin
      unique case (phase_r)
        ps2mpt_pkg::PhStatus: begin
          if (byte_ok) begin
            status_nxt = in_rx_byte;
            phase_nxt  = ps2mpt_pkg::PhDeltaX;
          end
        end
        ps2mpt_pkg::PhDeltaX: begin
          dx_nxt    = in_rx_byte;
          phase_nxt = ps2mpt_pkg::PhDeltaY;
        end
        default: begin
          cur_x_nxt     = clamp(sum_x, hi_x);
          cur_y_nxt     = clamp(sum_y, hi_y);
          wide_x        = WideW'(cur_x_nxt);
          wide_y        = WideW'(cur_y_nxt);
          pos_x_nxt     = wide_x[ps2mpt_pkg::PosW-1:0];
          pos_y_nxt     = wide_y[ps2mpt_pkg::PosW-1:0];
          left_nxt      = status_r[ps2mpt_pkg::StLeft];
          out_valid_nxt = 1'b1;
          phase_nxt     = ps2mpt_pkg::PhStatus;
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ps2mpt_pkg::PhStatus;
      status_r    <= '0;
      dx_r        <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
      width_r     <= ps2mpt_pkg::WidthReset;
      height_r    <= ps2mpt_pkg::HeightReset;
    end else begin
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      dx_r        <= dx_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ps2mpt_pkg::RegScreenWidth:  width_r  <= cfg_wdata;
          ps2mpt_pkg::RegScreenHeight: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    left_r  <= left_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_left_button = left_r;

  // a new result only follows a y-delta byte
  a_result_after_dy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r != ps2mpt_pkg::PhDeltaY) |=> !(out_valid_r && !$past(out_valid_r)))
    else $error("result raised without a y-delta byte");

  // the unused phase code never shows up
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= ps2mpt_pkg::PhDeltaY)
    else $error("packet phase reached unused code");

  // a held status byte always carries sync and no overflow
  a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != ps2mpt_pkg::PhStatus) |->
      (status_r[ps2mpt_pkg::StSync] && !status_r[ps2mpt_pkg::StOvfX]
       && !status_r[ps2mpt_pkg::StOvfY]))
    else $error("held status byte lacks sync or has overflow");

  // input stalls while a result waits unclaimed
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result is stalled");

endmodule

`default_nettype wire
